// ----- rtl/lzce_pkg.sv -----
// ----------------------------------------------------------------------------
// lzce_pkg: shared types and constants of the zero-crossing edge unit
// Command format passed from the front to the back, register codes and
// reset values.
// ----------------------------------------------------------------------------
package lzce_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned CoordW   = 9;
  localparam int unsigned InCoordW = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 9;
  localparam int unsigned WinW     = 4;
  localparam int unsigned HalfW    = WinW - 1;
  localparam int unsigned CmpW     = PixW + 3;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [WinW-1:0]     MaxWindow   = 4'd15;
  localparam logic [CfgDataW-1:0] WidthReset  = 9'd256;
  localparam logic [CfgDataW-1:0] HeightReset = 9'd256;
  localparam logic [WinW-1:0]     WindowReset = 4'd3;
  localparam logic [PixW-1:0]     ThreshReset = 8'd0;
  localparam logic [PixW-1:0]     PixMax      = 8'd255;
  localparam logic [PixW-1:0]     PixMin      = 8'd0;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1,
    CfgWindowSize  = 2'd2,
    CfgThreshold   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CmdLoad  = 2'd0,
    CmdQuery = 2'd1,
    CmdZero  = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [InCoordW-1:0]   col;
    logic [InCoordW-1:0]   row;
    logic [PixW-1:0]       pixel;
    logic [CoordW-1:0]     x_lo;
    logic [CoordW-1:0]     x_hi;
    logic [CoordW-1:0]     y_lo;
    logic [CoordW-1:0]     y_hi;
  } cmd_t;

endpackage

// ----- rtl/lzce_if.sv -----
// ----------------------------------------------------------------------------
// lzce_if: channel interfaces of the zero-crossing edge unit
// Input channel carries load and query items, output channel carries
// edge results. Valid/ready handshake on both.
// ----------------------------------------------------------------------------
interface lzce_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] pixel;

  modport source (output valid, output operation, output col, output row,
                  output pixel, input ready);
  modport sink   (input valid, input operation, input col, input row,
                  input pixel, output ready);
endinterface

interface lzce_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] edge_value;

  modport source (output valid, output edge_value, input ready);
  modport sink   (input valid, input edge_value, output ready);
endinterface

// ----- rtl/lzce_front.sv -----
// ----------------------------------------------------------------------------
// lzce_front: configuration registers and item classifier
// Holds the registers, checks coordinates against the active frame and
// precomputes the clamped window bounds of each query.
// ----------------------------------------------------------------------------
module lzce_front #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lzce_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [lzce_pkg::CfgDataW-1:0]    cfg_wdata_i,
  lzce_in_if.sink                          in_i,
  input  logic                             full_i,
  output logic                             push_o,
  output lzce_pkg::cmd_t                   cmd_o,
  output logic [lzce_pkg::PixW-1:0]        threshold_o
);

  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

  logic [lzce_pkg::CfgDataW-1:0] width_q, height_q;
  logic [lzce_pkg::WinW-1:0]     win_q;
  logic [lzce_pkg::PixW-1:0]     thresh_q;

  logic [lzce_pkg::CoordW-1:0]   w_act, h_act, col9, row9;
  logic [lzce_pkg::CoordW-1:0]   x_sum, y_sum, half9;
  logic [lzce_pkg::WinW-1:0]     ws;
  logic [lzce_pkg::HalfW-1:0]    half;
  logic                          in_frame;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lzce_pkg::WidthReset;
      height_q <= lzce_pkg::HeightReset;
      win_q    <= lzce_pkg::WindowReset;
      thresh_q <= lzce_pkg::ThreshReset;
    end else if (cfg_we_i) begin
      case (lzce_pkg::cfg_reg_e'(cfg_idx_i))
        lzce_pkg::CfgImageWidth:  width_q  <= cfg_wdata_i;
        lzce_pkg::CfgImageHeight: height_q <= cfg_wdata_i;
        lzce_pkg::CfgWindowSize:  win_q    <= cfg_wdata_i[lzce_pkg::WinW-1:0];
        lzce_pkg::CfgThreshold:   thresh_q <= cfg_wdata_i[lzce_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversize acts as the frame store limit.
  always_comb begin
    if (width_q == '0)            w_act = 9'd1;
    else if (13'(width_q) > MaxW) w_act = 9'(MaxW);
    else                          w_act = width_q;
    if (height_q == '0)            h_act = 9'd1;
    else if (13'(height_q) > MaxH) h_act = 9'(MaxH);
    else                           h_act = height_q;
  end

  assign ws       = (win_q > lzce_pkg::MaxWindow) ? lzce_pkg::MaxWindow : win_q;
  assign half     = ws[lzce_pkg::WinW-1:1];
  assign half9    = 9'(half);
  assign col9     = 9'(in_i.col);
  assign row9     = 9'(in_i.row);
  assign x_sum    = col9 + half9;
  assign y_sum    = row9 + half9;
  assign in_frame = (col9 < w_act) && (row9 < h_act);

  // Clamped window bounds: repeated border pixels do not change min or max.
  always_comb begin
    cmd_o.col   = in_i.col;
    cmd_o.row   = in_i.row;
    cmd_o.pixel = in_i.pixel;
    cmd_o.x_lo  = (col9 >= half9) ? col9 - half9 : '0;
    cmd_o.y_lo  = (row9 >= half9) ? row9 - half9 : '0;
    cmd_o.x_hi  = (x_sum > w_act - 9'd1) ? w_act - 9'd1 : x_sum;
    cmd_o.y_hi  = (y_sum > h_act - 9'd1) ? h_act - 9'd1 : y_sum;
    if (!in_i.operation)  cmd_o.kind = lzce_pkg::CmdLoad;
    else if (in_frame)    cmd_o.kind = lzce_pkg::CmdQuery;
    else                  cmd_o.kind = lzce_pkg::CmdZero;
  end

  // Drop loads outside the frame right here.
  assign in_i.ready  = !full_i;
  assign push_o      = in_i.valid && !full_i && (in_i.operation || in_frame);
  assign threshold_o = thresh_q;

endmodule

// ----- rtl/lzce_queue.sv -----
// ----------------------------------------------------------------------------
// lzce_queue: command queue between front and back
// Small FIFO of classified commands.
// ----------------------------------------------------------------------------
module lzce_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lzce_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output lzce_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned Depth = lzce_pkg::QueueDepth;
  localparam int unsigned PtrW  = lzce_pkg::QPtrW;
  localparam int unsigned CntW  = lzce_pkg::QCntW;

  lzce_pkg::cmd_t  entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop)      cnt_q <= cnt_q + CntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule

// ----- rtl/lzce_back.sv -----
// ----------------------------------------------------------------------------
// lzce_back: frame store, global range tracking and window scan
// Executes loads into the frame store and scans query windows one read
// per cycle, then applies the zero-crossing test.
// ----------------------------------------------------------------------------
module lzce_back #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  lzce_pkg::cmd_t            q_head_i,
  output logic                      q_pop_o,
  input  logic [lzce_pkg::PixW-1:0] threshold_i,
  lzce_out_if.source                out_o
);

  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned PixW  = lzce_pkg::PixW;
  localparam int unsigned CW    = lzce_pkg::CoordW;
  localparam int unsigned CmpW  = lzce_pkg::CmpW;

  typedef enum logic [1:0] {StIdle, StScan, StDrain, StDone} state_e;

  logic [PixW-1:0] frame_mem [Depth];

  state_e          state_q, state_d;
  lzce_pkg::cmd_t  cmd_q, cmd_d;
  logic [CW-1:0]   x_q, x_d, y_q, y_d;
  logic [PixW-1:0] lmin_q, lmin_d, lmax_q, lmax_d, ctr_q, ctr_d;
  logic [PixW-1:0] gmin_q, gmin_d, gmax_q, gmax_d;
  logic [PixW-1:0] out_val_q, out_val_d, rd_data_q;
  logic            zero_q, zero_d, out_vld_q, out_vld_d;
  logic            rd_vld_q, rd_ctr_q, rd_ctr_d, rd_en, we;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [CmpW-1:0]  sum, t2, lo_side, hi_side;
  logic             hit;

  assign wr_addr = AddrW'(q_head_i.row) * AddrW'(MAX_WIDTH) + AddrW'(q_head_i.col);
  assign rd_addr = AddrW'(y_q) * AddrW'(MAX_WIDTH) + AddrW'(x_q);

  always_ff @(posedge clk_i) begin
    if (we)    frame_mem[wr_addr] <= q_head_i.pixel;
    if (rd_en) rd_data_q <= frame_mem[rd_addr];
  end

  // Doubled-integer form of the test against the center of the global range.
  assign sum     = CmpW'(gmin_q) + CmpW'(gmax_q);
  assign t2      = CmpW'({threshold_i, 1'b0});
  assign lo_side = CmpW'({lmin_q, 1'b0}) + t2;
  assign hi_side = sum + t2;
  assign hit     = (lo_side < sum) && (CmpW'({lmax_q, 1'b0}) > hi_side);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    x_d       = x_q;
    y_d       = y_q;
    zero_d    = zero_q;
    gmin_d    = gmin_q;
    gmax_d    = gmax_q;
    lmin_d    = lmin_q;
    lmax_d    = lmax_q;
    ctr_d     = ctr_q;
    out_vld_d = out_vld_q && !out_o.ready;
    out_val_d = out_val_q;
    q_pop_o   = 1'b0;
    rd_en     = 1'b0;
    we        = 1'b0;
    rd_ctr_d  = 1'b0;

    // Fold returning read data into the local range.
    if (rd_vld_q) begin
      if (rd_data_q < lmin_q) lmin_d = rd_data_q;
      if (rd_data_q > lmax_q) lmax_d = rd_data_q;
      if (rd_ctr_q)           ctr_d  = rd_data_q;
    end

    case (state_q)
      StIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_head_i;
          case (q_head_i.kind)
            lzce_pkg::CmdLoad: begin
              we = 1'b1;
              if (q_head_i.col == '0 && q_head_i.row == '0) begin
                gmin_d = q_head_i.pixel;
                gmax_d = q_head_i.pixel;
              end else begin
                if (q_head_i.pixel < gmin_q) gmin_d = q_head_i.pixel;
                if (q_head_i.pixel > gmax_q) gmax_d = q_head_i.pixel;
              end
            end
            lzce_pkg::CmdQuery: begin
              x_d     = q_head_i.x_lo;
              y_d     = q_head_i.y_lo;
              lmin_d  = lzce_pkg::PixMax;
              lmax_d  = lzce_pkg::PixMin;
              zero_d  = 1'b0;
              state_d = StScan;
            end
            default: begin
              zero_d  = 1'b1;
              state_d = StDone;
            end
          endcase
        end
      end
      StScan: begin
        rd_en    = 1'b1;
        rd_ctr_d = (x_q == CW'(cmd_q.col)) && (y_q == CW'(cmd_q.row));
        if (x_q == cmd_q.x_hi) begin
          x_d = cmd_q.x_lo;
          if (y_q == cmd_q.y_hi) state_d = StDrain;
          else                   y_d = y_q + CW'(1);
        end else begin
          x_d = x_q + CW'(1);
        end
      end
      StDrain: begin
        state_d = StDone;
      end
      StDone: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_val_d = (!zero_q && hit) ? ctr_q : '0;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cmd_q     <= '0;
      x_q       <= '0;
      y_q       <= '0;
      zero_q    <= 1'b0;
      gmin_q    <= lzce_pkg::PixMax;
      gmax_q    <= lzce_pkg::PixMin;
      lmin_q    <= lzce_pkg::PixMax;
      lmax_q    <= lzce_pkg::PixMin;
      ctr_q     <= '0;
      out_vld_q <= 1'b0;
      out_val_q <= '0;
      rd_vld_q  <= 1'b0;
      rd_ctr_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmd_q     <= cmd_d;
      x_q       <= x_d;
      y_q       <= y_d;
      zero_q    <= zero_d;
      gmin_q    <= gmin_d;
      gmax_q    <= gmax_d;
      lmin_q    <= lmin_d;
      lmax_q    <= lmax_d;
      ctr_q     <= ctr_d;
      out_vld_q <= out_vld_d;
      out_val_q <= out_val_d;
      rd_vld_q  <= rd_en;
      rd_ctr_q  <= rd_ctr_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.edge_value = out_val_q;

endmodule

// ----- rtl/log_zero_crossing_edge_unit.sv -----
// ----------------------------------------------------------------------------
// log_zero_crossing_edge_unit: zero-crossing edge marker on a filtered frame
// Top level: front classifier, command queue and frame store back end.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries load and query transactions (operation, col, row, pixel).
//   A load writes one pixel into the frame store and updates the global
//   range; loading pixel (0,0) restarts that range. A load returns nothing.
//   A query returns exactly one transaction on out_o: the pixel's value when
//   the window around it crosses the center of the global range by more
//   than the threshold on both sides, else 0.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) are registered;
//   the user must issue them only while the unit is idle (not enforced).
// Timing:
//   A load is written to the frame store from the back end's idle state. A
//   query scans the N distinct pixels of its clamped window (9 for an
//   interior 3x3 window) through the single read port of the frame store,
//   one pixel read per cycle, then passes a drain and a done state. The back
//   end takes its next command only once the result is registered. A
//   two-entry queue lets the front accept while the back scans.
// Reset: registers return to their defaults, global range to min 255 and
//   max 0; the frame store is undefined until written.
// Stall: a held result stays in the output register; the back end stops in
//   its final state, the queue fills and in_i.ready drops.
// ----------------------------------------------------------------------------
module log_zero_crossing_edge_unit #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lzce_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lzce_pkg::CfgDataW-1:0] cfg_wdata_i,
  lzce_in_if.sink                       in_i,
  lzce_out_if.source                    out_o
);

  // Classified commands travel front -> queue -> back.
  lzce_pkg::cmd_t             q_cmd, q_head;
  logic                       q_push, q_pop, q_full, q_empty;
  logic [lzce_pkg::PixW-1:0]  threshold;

  lzce_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .full_i      (q_full),
    .push_o      (q_push),
    .cmd_o       (q_cmd),
    .threshold_o (threshold)
  );

  lzce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // Back end drains the queue and owns the result register.
  lzce_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (!q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .threshold_i (threshold),
    .out_o       (out_o)
  );

  // Front must never push into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("push into full command queue");

  // Back end must only pop a non-empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("pop from empty command queue");

  // A load transaction never raises a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop && (q_head.kind == lzce_pkg::CmdLoad)) |=> !$rose(out_o.valid))
    else $error("result raised after a load");

endmodule
